### hdl/ccmd_pkg.sv
// Shared types and codes for the channel change module dispatcher.
// Holds the channel beat structs, request and result codes, and the
// controller/datapath command and status bundles. No dependencies.
package ccmd_pkg;

  localparam int unsigned CHAN_SLOTS = 32;  // storage fixed by the 5-bit index
  localparam int unsigned SETUP_REGS = 4;   // module setup registers in the map

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_NEXT  = 2'd3
  } req_t;

  localparam logic [2:0] KIND_ACK  = 3'd0;
  localparam logic [2:0] KIND_READ = 3'd1;
  localparam logic [2:0] KIND_FIRE = 3'd2;
  localparam logic [2:0] KIND_END  = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  localparam logic [2:0] CFG_USED   = 3'd0;
  localparam logic [2:0] CFG_COUNT  = 3'd1;
  localparam logic [2:0] CFG_SETUP0 = 3'd2;
  localparam logic [2:0] CFG_SETUP3 = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  channel_index;
    logic [31:0] write_word;
    logic [15:0] step_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  fired_module;
    logic [31:0] read_word;
    logic [6:0]  round_number;
    logic        limit_reached;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       wr;         // store write beat
    logic       rd;         // fetch read word
    logic       step;       // load step time, open step
    logic       check;      // latch hit, clear changed bits
    logic       mod_step;   // advance prescalers of mod_idx
    logic [1:0] mod_idx;
    logic       emit;
    logic [2:0] emit_kind;
    logic       emit_last;
    logic       round_inc;
  } cmd_t;

  typedef struct packed {
    logic       hit_zero;
    logic       go;
    logic       active;
    logic [2:0] mod_n;
    logic       slot_free;
  } sts_t;

endpackage

### hdl/ccmd_ctrl.sv
// Controller of the dispatcher: one-hot sequencer that accepts requests,
// walks the modules of a round and orders result beats. Uses ccmd_pkg.
module ccmd_ctrl import ccmd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] req_type,
  output logic       in_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ACK   = 6'b000010,
    S_RD    = 6'b000100,
    S_CHECK = 6'b001000,
    S_MOD   = 6'b010000,
    S_END   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.mod_idx = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (req_t'(req_type))
            REQ_WRITE: begin
              cmd.wr = 1'b1;
              state_nxt = S_ACK;
            end
            REQ_READ: begin
              cmd.rd = 1'b1;
              state_nxt = S_RD;
            end
            REQ_STEP: begin
              cmd.step = 1'b1;
              state_nxt = S_CHECK;
            end
            REQ_NEXT: begin
              if (sts.active) state_nxt = S_CHECK;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ACK, S_RD: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = (state_r == S_ACK) ? KIND_ACK : KIND_READ;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_CHECK: begin
        if (sts.hit_zero) begin
          if (sts.slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_DONE;
            cmd.emit_last = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.check = 1'b1;
          idx_nxt   = 2'd0;
          state_nxt = (sts.mod_n == 3'd0) ? S_END : S_MOD;
        end
      end
      S_MOD: begin
        // hold while a fire beat has no slot
        if (!sts.go || sts.slot_free) begin
          cmd.mod_step  = 1'b1;
          cmd.emit      = sts.go;
          cmd.emit_kind = KIND_FIRE;
          if ({1'b0, idx_r} == sts.mod_n - 3'd1) begin
            state_nxt = S_END;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      S_END: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_END;
          cmd.emit_last = 1'b1;
          cmd.round_inc = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### hdl/ccmd_dp.sv
// Datapath of the dispatcher: channel word memory, changed bits, config
// registers, per-module prescalers and the output register. Uses ccmd_pkg.
module ccmd_dp import ccmd_pkg::*; #(
  parameter int unsigned CHANNELS   = 32,
  parameter int unsigned MODULES    = 4,
  parameter int unsigned MAX_ROUNDS = 125
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        out_stall,
  output logic        out_valid,
  output out_item_t   out_data,
  input  cmd_t        cmd,
  output sts_t        sts
);

  localparam logic [31:0] CHAN_MASK = (CHANNELS >= 32) ? 32'hFFFF_FFFF
                                    : ((32'd1 << CHANNELS) - 32'd1);
  localparam logic [5:0]  CHAN_LIM  = 6'(CHANNELS);
  localparam logic [2:0]  MOD_LIM   = 3'(MODULES);
  localparam logic [6:0]  ROUND_LIM = 7'(MAX_ROUNDS);

  logic [31:0] mem [CHAN_SLOTS];
  logic [31:0] mem_vld_r;
  logic [31:0] rd_raw_r;
  logic        rd_ok_r;

  logic [31:0] used_r;
  logic [2:0]  count_r;
  logic [63:0] setup_r [SETUP_REGS];
  logic [15:0] skip_r  [SETUP_REGS];
  logic [17:0] wait_r  [SETUP_REGS];

  logic [31:0] changed_r;
  logic [31:0] hit_r;
  logic [15:0] held_r;
  logic [6:0]  round_r;
  logic        active_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic        in_range;
  logic        mem_we;
  logic [4:0]  mem_wa;
  logic [31:0] mem_wd;
  logic [31:0] hit_now;
  logic [6:0]  round_inc;
  logic        limit_next;

  logic [63:0] cur_setup;
  logic [15:0] epre, tpre, skip_inc, skip_nxt;
  logic [17:0] wait_sub, wait_nxt;
  logic        go;

  assign in_range   = {1'b0, in_data.channel_index} < CHAN_LIM;
  assign hit_now    = changed_r & used_r & CHAN_MASK;
  assign round_inc  = round_r + 7'd1;
  assign limit_next = round_inc >= ROUND_LIM;

  assign mem_we = (cmd.wr && in_range) || cmd.step;
  assign mem_wa = cmd.step ? 5'd0 : in_data.channel_index;
  assign mem_wd = cmd.step ? {16'd0, in_data.step_time} : in_data.write_word;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd) rd_raw_r <= mem[in_data.channel_index];
  end

  // prescaler evaluation for the module in turn
  always_comb begin
    cur_setup = setup_r[cmd.mod_idx];
    epre      = cur_setup[47:32];
    tpre      = cur_setup[63:48];
    go        = (hit_r & cur_setup[31:0]) != 32'd0;
    skip_inc  = skip_r[cmd.mod_idx] + 16'd1;
    skip_nxt  = skip_r[cmd.mod_idx];
    wait_sub  = wait_r[cmd.mod_idx] - {2'b00, held_r};
    wait_nxt  = wait_r[cmd.mod_idx];
    if (epre != 16'd0) begin
      if (skip_inc == epre) begin
        skip_nxt = 16'd0;
      end else begin
        skip_nxt = skip_inc;
        go = 1'b0;
      end
    end
    if (tpre != 16'd0) begin
      if (wait_sub[17]) begin
        wait_nxt = {2'b00, tpre};
      end else begin
        wait_nxt = wait_sub;
        go = 1'b0;
      end
    end
  end

  always_comb begin
    sts.hit_zero  = (hit_now == 32'd0);
    sts.go        = go;
    sts.active    = active_r;
    sts.mod_n     = (count_r > MOD_LIM) ? MOD_LIM : count_r;
    sts.slot_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r   <= '0;
      rd_ok_r     <= 1'b0;
      used_r      <= 32'd1;
      count_r     <= 3'd0;
      changed_r   <= '0;
      held_r      <= '0;
      round_r     <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SETUP_REGS; i++) begin
        setup_r[i] <= '0;
        skip_r[i]  <= '0;
        wait_r[i]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_USED) used_r <= cfg_data[31:0];
        else if (cfg_index == CFG_COUNT) count_r <= cfg_data[2:0];
        else if (cfg_index >= CFG_SETUP0 && cfg_index <= CFG_SETUP3) begin
          setup_r[2'(cfg_index - CFG_SETUP0)] <= cfg_data;
          skip_r[2'(cfg_index - CFG_SETUP0)]  <= '0;
          wait_r[2'(cfg_index - CFG_SETUP0)]  <= {2'b00, cfg_data[63:48]};
        end
      end
      if (cmd.wr && in_range) begin
        mem_vld_r[in_data.channel_index] <= 1'b1;
        changed_r[in_data.channel_index] <= 1'b1;
      end
      if (cmd.rd) rd_ok_r <= in_range && mem_vld_r[in_data.channel_index];
      if (cmd.step) begin
        held_r       <= in_data.step_time;
        mem_vld_r[0] <= 1'b1;
        changed_r[0] <= 1'b1;
        round_r      <= '0;
        active_r     <= 1'b1;
      end
      if (cmd.check) begin
        hit_r     <= hit_now;
        changed_r <= '0;
      end
      if (cmd.mod_step) begin
        skip_r[cmd.mod_idx] <= skip_nxt;
        wait_r[cmd.mod_idx] <= wait_nxt;
      end
      if (cmd.round_inc) begin
        round_r <= round_inc;
        if (limit_next) active_r <= 1'b0;
      end
      if (cmd.emit && cmd.emit_kind == KIND_DONE) active_r <= 1'b0;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.kind          <= cmd.emit_kind;
      out_r.fired_module  <= (cmd.emit_kind == KIND_FIRE) ? cmd.mod_idx : 2'd0;
      out_r.read_word     <= (cmd.emit_kind == KIND_READ && rd_ok_r) ? rd_raw_r : 32'd0;
      out_r.round_number  <= (cmd.emit_kind == KIND_END) ? round_inc
                           : (cmd.emit_kind == KIND_FIRE || cmd.emit_kind == KIND_DONE)
                             ? round_r : 7'd0;
      out_r.limit_reached <= (cmd.emit_kind == KIND_END) && limit_next;
      out_r.last          <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hdl/channel_change_module_dispatcher.sv
// Top level of the channel change module dispatcher.
// Joins the controller (ccmd_ctrl) and datapath (ccmd_dp); uses ccmd_pkg.
//
// Write and read requests are taken in the idle state; their single result
// beat enters the output register from the acknowledge or read state once
// an output slot is free. A round takes the request in the idle state, tests
// the changed channels in the check state, then steps each registered module
// (module_count, at most MODULES) in the module state and gives the round-end
// beat from the end state, for a step request or next-round request; an empty
// round gives its step-done beat from the check state. A new request is taken
// only once the previous one has placed its last beat in the output register;
// output stalls hold the state. Configuration writes are taken in every cycle.
module channel_change_module_dispatcher import ccmd_pkg::*; #(
  parameter int unsigned CHANNELS   = 32,
  parameter int unsigned MODULES    = 4,
  parameter int unsigned MAX_ROUNDS = 125
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ccmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccmd_dp #(
    .CHANNELS   (CHANNELS),
    .MODULES    (MODULES),
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### hdl/ccmd_checker.sv
// Port-level checks for the channel change module dispatcher.
// Bound to the top level; uses ccmd_pkg.
module ccmd_checker import ccmd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_FIRE |-> !out_data.last)
    else $error("fire beat marked last");

  a_io_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_ACK || out_data.kind == KIND_READ)
    |-> out_data.round_number == 7'd0 && !out_data.limit_reached && out_data.last)
    else $error("bad write ack or read beat");

  a_limit_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.limit_reached |-> out_data.kind == KIND_END && out_data.last)
    else $error("limit flag outside round end");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind channel_change_module_dispatcher ccmd_checker u_ccmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
